@@ rtl/lbfe_pkg.sv @@
// ----------------------------------------------------------------------------
// lbfe_pkg: shared types and constants of the LSB-first bit field extractor.
// Holds the command and status codes, the classified operation record passed
// from the front end to the back end, and the sizing of the bit reservoir.
// ----------------------------------------------------------------------------
package lbfe_pkg;

   // Reservoir sizing. The usable capacity is capped so the count fits 7 bits.
   localparam int RESERVOIR_BITS = 64;
   localparam int RES_CAP        = (RESERVOIR_BITS > 127) ? 127 : RESERVOIR_BITS;
   localparam int CNT_W          = 7;

   // Field widths of the channels.
   localparam int WORD_W  = 32;
   localparam int BYTES_W = 3;
   localparam int LEN_W   = 6;
   localparam int CMD_W   = 2;
   localparam int STAT_W  = 2;

   // Clamp limits of the input fields.
   localparam int MAX_BYTES = 4;
   localparam int MAX_LEN   = 32;

   // Prefixed integer layout.
   localparam int VAR_PREFIX_BITS = 6;
   localparam int VAR_LOW_BITS    = 4;
   localparam int VAR_EXT_NIBBLE  = 4;
   localparam int VAR_EXT_BYTE    = 8;
   localparam int VAR_EXT_WIDE    = 28;

   // Queue between the front end and the back end.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD   = 2'd0,
      CMD_READ   = 2'd1,
      CMD_VARINT = 2'd2,
      CMD_IDLE   = 2'd3
   } command_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK    = 2'd0,
      ST_UNDER = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // One classified item as the back end sees it.
   typedef struct packed {
      command_type         command;
      logic [WORD_W-1:0]   data_word;   // already masked to nbits
      logic [LEN_W-1:0]    nbits;       // bits a load appends, 0 to 32
      logic [LEN_W-1:0]    len;         // bits a fixed read takes, 0 to 32
   } op_type;

   // Mask of the n low bits of a word, n from 0 to 32.
   function automatic logic [WORD_W-1:0] low_mask(input logic [LEN_W-1:0] n);
      logic [WORD_W-1:0] mask;
      if (n == '0) begin
         mask = '0;
      end else begin
         mask = {WORD_W{1'b1}} >> (LEN_W'(WORD_W) - n);
      end
      return mask;
   endfunction

endpackage

@@ rtl/lbfe_if.sv @@
// ----------------------------------------------------------------------------
// lbfe_if: valid/ready channels of the bit field extractor.
// lbfe_req_if carries command items in, lbfe_rsp_if carries result items out.
// ----------------------------------------------------------------------------
interface lbfe_req_if;
   logic                             valid;
   logic                             ready;
   logic [lbfe_pkg::CMD_W-1:0]       command;
   logic [lbfe_pkg::WORD_W-1:0]      data_word;
   logic [lbfe_pkg::BYTES_W-1:0]     valid_bytes;
   logic [lbfe_pkg::LEN_W-1:0]       field_length;

   modport source (output valid, command, data_word, valid_bytes, field_length,
                   input ready);
   modport sink   (input valid, command, data_word, valid_bytes, field_length,
                   output ready);
endinterface

interface lbfe_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [lbfe_pkg::WORD_W-1:0]      field_value;
   logic [lbfe_pkg::STAT_W-1:0]      status;
   logic [lbfe_pkg::CNT_W-1:0]       bits_held;

   modport source (output valid, field_value, status, bits_held, input ready);
   modport sink   (input valid, field_value, status, bits_held, output ready);
endinterface

@@ rtl/lbfe_front.sv @@
// ----------------------------------------------------------------------------
// lbfe_front: accepts command items, classifies them and queues them.
// Clamps byte counts and field lengths, masks load data and holds the
// classified operations in a short queue for the back end.
// ----------------------------------------------------------------------------
module lbfe_front (
   input  logic              clock,
   input  logic              reset,
   lbfe_req_if.sink          req,
   output logic              op_valid,
   output lbfe_pkg::op_type  op,
   input  logic              op_ready
);

   lbfe_pkg::op_type                  entry_ff [lbfe_pkg::QUEUE_DEPTH];
   logic [lbfe_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [lbfe_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [lbfe_pkg::QCNT_W-1:0]       count_ff, count_in;
   lbfe_pkg::op_type                  class_op;
   logic [lbfe_pkg::BYTES_W-1:0]      nbytes;
   logic                              push;
   logic                              pop;

   // Classify the incoming item.
   always_comb begin
      if (req.valid_bytes > lbfe_pkg::BYTES_W'(lbfe_pkg::MAX_BYTES)) begin
         nbytes = lbfe_pkg::BYTES_W'(lbfe_pkg::MAX_BYTES);
      end else begin
         nbytes = req.valid_bytes;
      end
      class_op.command   = lbfe_pkg::command_type'(req.command);
      class_op.nbits     = {nbytes, 3'b000};
      class_op.data_word = req.data_word & lbfe_pkg::low_mask({nbytes, 3'b000});
      if (req.field_length > lbfe_pkg::LEN_W'(lbfe_pkg::MAX_LEN)) begin
         class_op.len = lbfe_pkg::LEN_W'(lbfe_pkg::MAX_LEN);
      end else begin
         class_op.len = req.field_length;
      end
   end

   // Queue handshakes.
   assign req.ready = (count_ff != lbfe_pkg::QCNT_W'(lbfe_pkg::QUEUE_DEPTH));
   assign push      = req.valid && req.ready;
   assign op_valid  = (count_ff != '0);
   assign pop       = op_valid && op_ready;
   assign op        = entry_ff[rd_ptr_ff];

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         if (wr_ptr_ff == lbfe_pkg::QPTR_W'(lbfe_pkg::QUEUE_DEPTH - 1)) begin
            wr_ptr_in = '0;
         end else begin
            wr_ptr_in = wr_ptr_ff + 1'b1;
         end
      end
      if (pop) begin
         if (rd_ptr_ff == lbfe_pkg::QPTR_W'(lbfe_pkg::QUEUE_DEPTH - 1)) begin
            rd_ptr_in = '0;
         end else begin
            rd_ptr_in = rd_ptr_ff + 1'b1;
         end
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage holds payload only.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= class_op;
      end
   end

endmodule

@@ rtl/lbfe_back.sv @@
// ----------------------------------------------------------------------------
// lbfe_back: executes classified operations on the bit reservoir.
// Appends load data above the held bits, extracts fixed and prefixed fields
// from the bottom, and registers one result item per operation.
// ----------------------------------------------------------------------------
module lbfe_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              op_valid,
   input  lbfe_pkg::op_type  op,
   output logic              op_ready,
   lbfe_rsp_if.source        rsp
);

   localparam int RES_W = lbfe_pkg::RESERVOIR_BITS;
   localparam int SH_W  = lbfe_pkg::LEN_W;
   localparam int EXT_W = lbfe_pkg::VAR_EXT_WIDE;
   localparam int EXT_LO = lbfe_pkg::VAR_PREFIX_BITS;

   // Prefix bits 5:4 select the extension length.
   typedef enum logic [1:0] {
      VX_NONE   = 2'd0,
      VX_NIBBLE = 2'd1,
      VX_BYTE   = 2'd2,
      VX_WIDE   = 2'd3
   } varsel_type;

   logic [RES_W-1:0]                  res_ff, res_in;
   logic [lbfe_pkg::CNT_W-1:0]        cnt_ff, cnt_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [lbfe_pkg::WORD_W-1:0]       value_ff, value_in;
   lbfe_pkg::status_type              status_ff, status_in;
   logic [lbfe_pkg::CNT_W-1:0]        held_ff;
   logic                              fire;
   logic [lbfe_pkg::CNT_W:0]          load_sum;
   logic [SH_W-1:0]                   extra;
   logic [SH_W-1:0]                   var_need;
   logic [EXT_W-1:0]                  ext_mask;
   varsel_type                        varsel;

   assign op_ready = !rsp_valid_ff || rsp.ready;
   assign fire     = op_valid && op_ready;

   // Extension length of a prefixed integer.
   always_comb begin
      varsel = varsel_type'(res_ff[lbfe_pkg::VAR_PREFIX_BITS-1 -: 2]);
      case (varsel)
         VX_NIBBLE: extra = SH_W'(lbfe_pkg::VAR_EXT_NIBBLE);
         VX_BYTE:   extra = SH_W'(lbfe_pkg::VAR_EXT_BYTE);
         VX_WIDE:   extra = SH_W'(lbfe_pkg::VAR_EXT_WIDE);
         default:   extra = '0;
      endcase
      var_need = SH_W'(lbfe_pkg::VAR_PREFIX_BITS) + extra;
      ext_mask = EXT_W'(lbfe_pkg::low_mask(extra));
   end

   // Execute one operation against the reservoir.
   always_comb begin
      res_in    = res_ff;
      cnt_in    = cnt_ff;
      value_in  = '0;
      status_in = lbfe_pkg::ST_OK;
      load_sum  = {1'b0, cnt_ff} + (lbfe_pkg::CNT_W + 1)'(op.nbits);
      case (op.command)
         lbfe_pkg::CMD_LOAD: begin
            if (load_sum > (lbfe_pkg::CNT_W + 1)'(lbfe_pkg::RES_CAP)) begin
               status_in = lbfe_pkg::ST_FULL;
            end else begin
               res_in = res_ff | (RES_W'(op.data_word) << cnt_ff);
               cnt_in = load_sum[lbfe_pkg::CNT_W-1:0];
            end
         end
         lbfe_pkg::CMD_READ: begin
            if (op.len != '0) begin
               if (cnt_ff < lbfe_pkg::CNT_W'(op.len)) begin
                  status_in = lbfe_pkg::ST_UNDER;
               end else begin
                  value_in = res_ff[lbfe_pkg::WORD_W-1:0] & lbfe_pkg::low_mask(op.len);
                  res_in   = res_ff >> op.len;
                  cnt_in   = cnt_ff - lbfe_pkg::CNT_W'(op.len);
               end
            end
         end
         lbfe_pkg::CMD_VARINT: begin
            // Bits above the count are zero, so a short prefix also fails here.
            if (cnt_ff < lbfe_pkg::CNT_W'(var_need)) begin
               status_in = lbfe_pkg::ST_UNDER;
            end else begin
               value_in = {res_ff[EXT_LO +: EXT_W] & ext_mask,
                           res_ff[lbfe_pkg::VAR_LOW_BITS-1:0]};
               res_in   = res_ff >> var_need;
               cnt_in   = cnt_ff - lbfe_pkg::CNT_W'(var_need);
            end
         end
         default: begin
            status_in = lbfe_pkg::ST_OK;
         end
      endcase
   end

   // Result register: filled on execution, drained by the receiver.
   always_comb begin
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            res_ff <= res_in;
            cnt_ff <= cnt_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         value_ff  <= value_in;
         status_ff <= status_in;
         held_ff   <= cnt_in;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.field_value = value_ff;
   assign rsp.status      = status_ff;
   assign rsp.bits_held   = held_ff;

endmodule

@@ rtl/lsb_bit_field_extractor_varint.sv @@
// ----------------------------------------------------------------------------
// lsb_bit_field_extractor_varint: LSB-first bit unpacker with prefixed ints.
// Top level joining the classifying front end, its queue and the executing
// back end.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries command items: a load appends 0 to 4 low bytes of
//   data_word above the bits held, a fixed read takes field_length bits from
//   the bottom, and a varint read takes a 6-bit prefix plus 0, 4, 8 or 28
//   extension bits. rsp_chan returns one item per command with the extracted
//   value, a status (ok, underflow, full) and the bit count left held.
//   An accepted item passes through the queue and then the result register
//   before its result is valid. Throughput is one item per cycle while the
//   receiver takes results: the two-entry queue feeds the back end every cycle,
//   and the single reservoir update per item is the loop that sets this figure.
//   When the receiver stalls, the result register holds its item, the back
//   end stops, and the queue absorbs up to two more items before req_chan
//   drops ready. Reset empties the queue, the result register and the
//   reservoir; no clearing pass is needed.
// ----------------------------------------------------------------------------
module lsb_bit_field_extractor_varint (
   input  logic         clock,
   input  logic         reset,
   lbfe_req_if.sink     req_chan,
   lbfe_rsp_if.source   rsp_chan
);

   logic              op_valid;
   logic              op_ready;
   lbfe_pkg::op_type  op;

   lbfe_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req      (req_chan),
      .op_valid (op_valid),
      .op       (op),
      .op_ready (op_ready)
   );

   lbfe_back u_back (
      .clock    (clock),
      .reset    (reset),
      .op_valid (op_valid),
      .op       (op),
      .op_ready (op_ready),
      .rsp      (rsp_chan)
   );

   // The held count never exceeds the reservoir capacity.
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.bits_held <= lbfe_pkg::CNT_W'(lbfe_pkg::RES_CAP)))
      else $error("bits_held exceeds reservoir capacity");

   // Errors carry a zero value.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && (rsp_chan.status != lbfe_pkg::ST_OK)) |->
         (rsp_chan.field_value == '0))
      else $error("error result with nonzero value");

   // The back end must not execute while a stalled result is pending.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.ready) |-> !op_ready)
      else $error("back end ready while result stalled");

   // A full status only follows a load, which never shrinks the count.
   assert property (@(posedge clock) disable iff (reset)
      (op_valid && op_ready && (op.command != lbfe_pkg::CMD_LOAD)) |=>
         (rsp_chan.status != lbfe_pkg::ST_FULL))
      else $error("full status on a read");

endmodule

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: self-checking bench of the LSB-first bit field extractor.
// A scoreboard class keeps its own copy of the bit reservoir, predicts the
// result of every accepted command item and compares each result item field
// by field. Directed items cover the edge cases first, then random phases
// run with different amounts of idling on both channels.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import lbfe_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int DRAIN_CYCLES = 10;

   typedef struct {
      command_type       command;
      logic [WORD_W-1:0] data_word;
      logic [2:0]        valid_bytes;
      logic [5:0]        field_length;
   } command_item_type;

   typedef struct {
      logic [WORD_W-1:0] field_value;
      status_type        status;
      logic [CNT_W-1:0]  bits_held;
   } result_item_type;

   // Scoreboard with its own reservoir and the queue of expected results.
   class unpack_tracker;
      logic [127:0]    reservoir;
      int              held;
      int              errors;
      result_item_type expected_fields[$];

      function new();
         reservoir = '0;
         held = 0;
         errors = 0;
      endfunction

      // Mask of the n low bits, n from 0 to 32.
      function logic [63:0] ones(int n);
         return (64'd1 << n) - 64'd1;
      endfunction

      // Work out the result of one accepted command and queue it.
      function void note_command(command_item_type cmd);
         result_item_type res;
         int nbits;
         int len;
         int extra;
         logic [5:0] prefix;
         logic [63:0] ext;
         res.field_value = '0;
         res.status = ST_OK;
         case (cmd.command)
            CMD_LOAD: begin
               nbits = (cmd.valid_bytes > MAX_BYTES) ? MAX_BYTES * 8 : cmd.valid_bytes * 8;
               if (held + nbits > RES_CAP) begin
                  res.status = ST_FULL;
               end else begin
                  reservoir = reservoir | (128'(64'(cmd.data_word) & ones(nbits)) << held);
                  held = held + nbits;
               end
            end
            CMD_READ: begin
               len = (cmd.field_length > MAX_LEN) ? MAX_LEN : cmd.field_length;
               if (len != 0) begin
                  if (held < len) begin
                     res.status = ST_UNDER;
                  end else begin
                     res.field_value = 32'(reservoir[63:0] & ones(len));
                     reservoir = reservoir >> len;
                     held = held - len;
                  end
               end
            end
            CMD_VARINT: begin
               if (held < 6) begin
                  res.status = ST_UNDER;
               end else begin
                  prefix = reservoir[5:0];
                  case (prefix[5:4])
                     2'b01: extra = 4;
                     2'b10: extra = 8;
                     2'b11: extra = 28;
                     default: extra = 0;
                  endcase
                  // The prefix and its extension bits must both be present.
                  if (held < 6 + extra) begin
                     res.status = ST_UNDER;
                  end else begin
                     ext = (reservoir[69:6] & ones(extra));
                     if (extra == 0) begin
                        res.field_value = 32'(prefix);
                     end else begin
                        res.field_value = 32'(prefix[3:0]) | 32'(ext << 4);
                     end
                     reservoir = reservoir >> (6 + extra);
                     held = held - 6 - extra;
                  end
               end
            end
            default: begin
               // The idle command leaves everything as it is.
            end
         endcase
         res.bits_held = CNT_W'(held);
         expected_fields.push_back(res);
      endfunction

      // Compare one result item with the oldest expectation.
      function void check_result(logic [WORD_W-1:0] value, logic [STAT_W-1:0] status,
                                 logic [CNT_W-1:0] bits_held);
         result_item_type want;
         if (expected_fields.size() == 0) begin
            $error("result item arrived with no expectation waiting");
            errors++;
            return;
         end
         want = expected_fields.pop_front();
         if (value !== want.field_value) begin
            $error("field_value: expected %h, actual %h", want.field_value, value);
            errors++;
         end
         if (status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status);
            errors++;
         end
         if (bits_held !== want.bits_held) begin
            $error("bits_held: expected %0d, actual %0d", want.bits_held, bits_held);
            errors++;
         end
      endfunction

      function int pending();
         return expected_fields.size();
      endfunction
   endclass

   logic clock;
   logic reset;

   lbfe_req_if req_bus();
   lbfe_rsp_if rsp_bus();

   lsb_bit_field_extractor_varint uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   unpack_tracker tracker = new();
   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   int hold_left = 0;
   int quiet_cycles = 0;

   // Clock generation.
   always #10 clock = ~clock;

   // Receiver: random stalls, plus a long hold-off when one is requested.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_bus.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= receiver_stall_pct);
         end
      end
   end

   // Result checker.
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         tracker.check_result(rsp_bus.field_value, rsp_bus.status, rsp_bus.bits_held);
      end
   end

   // Watchdog on cycles in which neither channel moves an item.
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Offer one command item, after random idle cycles, and note it on acceptance.
   task automatic send_command(command_type command, logic [WORD_W-1:0] word,
                               logic [2:0] nbytes, logic [5:0] len);
      command_item_type cmd;
      cmd.command = command;
      cmd.data_word = word;
      cmd.valid_bytes = nbytes;
      cmd.field_length = len;
      if (sender_idle_pct > 0) begin
         while ($urandom_range(99) < sender_idle_pct) begin
            req_bus.valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_bus.valid <= 1'b1;
      req_bus.command <= command;
      req_bus.data_word <= word;
      req_bus.valid_bytes <= nbytes;
      req_bus.field_length <= len;
      do @(posedge clock); while (!req_bus.ready);
      tracker.note_command(cmd);
   endtask

   // Random items: mostly sensible loads and reads, some noise.
   task automatic run_random_phase(int count, int idle_pct, int stall_pct);
      int pick;
      int have;
      int top;
      sender_idle_pct = idle_pct;
      receiver_stall_pct = stall_pct;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(99);
         have = tracker.held;
         top = (have > MAX_LEN) ? MAX_LEN : have;
         if (pick < 15) begin
            send_command(command_type'($urandom_range(3)), $urandom, 3'($urandom_range(7)),
                         6'($urandom_range(63)));
         end else if (have < 8 || (have < 34 && pick < 60)) begin
            send_command(CMD_LOAD, $urandom, 3'($urandom_range(4, 1)),
                         6'($urandom_range(63)));
         end else if (pick < 80) begin
            send_command(CMD_READ, $urandom, 3'($urandom_range(7)),
                         6'($urandom_range(top, 1)));
         end else begin
            send_command(CMD_VARINT, $urandom, 3'($urandom_range(7)),
                         6'($urandom_range(63)));
         end
      end
      // Pause the sender until every expected result has come back.
      req_bus.valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
   endtask

   // Main sequence.
   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.command = CMD_IDLE;
      req_bus.data_word = '0;
      req_bus.valid_bytes = '0;
      req_bus.field_length = '0;
      rsp_bus.ready = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Empty reservoir, idle command and a load of nothing.
      send_command(CMD_READ, '0, 3'd0, 6'd1);
      send_command(CMD_VARINT, '0, 3'd0, 6'd0);
      send_command(CMD_IDLE, '1, 3'd7, 6'd63);
      send_command(CMD_LOAD, '1, 3'd0, 6'd0);
      // Fill to capacity, with an oversized byte count, then overflow.
      send_command(CMD_LOAD, '1, 3'd4, 6'd0);
      send_command(CMD_LOAD, 32'h1234_5678, 3'd7, 6'd0);
      send_command(CMD_LOAD, 32'h0000_00a5, 3'd1, 6'd0);
      // Zero-length read, an oversized length and a full-width read.
      send_command(CMD_READ, '0, 3'd0, 6'd0);
      send_command(CMD_READ, '0, 3'd0, 6'd63);
      send_command(CMD_READ, '0, 3'd0, 6'd32);
      // Short varint with no extension.
      send_command(CMD_LOAD, 32'h0000_000f, 3'd1, 6'd0);
      send_command(CMD_VARINT, '0, 3'd0, 6'd0);
      send_command(CMD_READ, '0, 3'd0, 6'd2);
      // Varint with a nibble of extension.
      send_command(CMD_LOAD, 32'h0000_03da, 3'd2, 6'd0);
      send_command(CMD_VARINT, '0, 3'd0, 6'd0);
      send_command(CMD_READ, '0, 3'd0, 6'd6);
      // Varint with a byte of extension, first missing its extension bits.
      send_command(CMD_LOAD, 32'h0000_002c, 3'd1, 6'd0);
      send_command(CMD_VARINT, '0, 3'd0, 6'd0);
      send_command(CMD_LOAD, 32'h0000_ffff, 3'd2, 6'd0);
      send_command(CMD_VARINT, '0, 3'd0, 6'd0);
      send_command(CMD_READ, '0, 3'd0, 6'd10);
      // Wide varint, first short by two bits.
      send_command(CMD_LOAD, '1, 3'd4, 6'd0);
      send_command(CMD_VARINT, '0, 3'd0, 6'd0);
      send_command(CMD_LOAD, '0, 3'd4, 6'd0);
      send_command(CMD_VARINT, '0, 3'd0, 6'd0);
      send_command(CMD_READ, '0, 3'd0, 6'd30);
      req_bus.valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);

      // The receiver holds off while the sender keeps offering items.
      hold_left = HOLD_OFF_CYCLES;
      run_random_phase(150, 0, 0);
      run_random_phase(150, 88, 0);
      run_random_phase(150, 0, 88);
      run_random_phase(150, 6, 6);

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tracker.errors == 0 && tracker.pending() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/lbfe_pkg.sv
rtl/lbfe_if.sv
rtl/lbfe_front.sv
rtl/lbfe_back.sv
rtl/lsb_bit_field_extractor_varint.sv
tb/sv/testbench.sv
